FILE: hdl/prbb_pkg.sv
`timescale 1ns / 1ps

package prbb_pkg;

    localparam int MODE_W  = 3;
    localparam int FIELD_W = 64;
    localparam int POS_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SETR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SETW = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
        logic pop_step;
    } t_cmd;

    typedef struct packed {
        logic pop_go;
        logic need_mod;
        logic mod_done;
        logic pop_last;
    } t_stat;

endpackage

FILE: hdl/prbb_ram.sv
`timescale 1ns / 1ps

module prbb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/prbb_mod.sv
`timescale 1ns / 1ps

module prbb_mod #(
    parameter int DIVISOR = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [prbb_pkg::POS_W-1:0] i_value,
    output logic                       o_done,
    output logic [$clog2(DIVISOR)-1:0] o_rem
);

    import prbb_pkg::*;

    localparam int  AW    = $clog2(DIVISOR);
    localparam int  PW    = POS_W + 33;
    localparam bit  POW2  = ((DIVISOR & (DIVISOR - 1)) == 0);

    // q = floor(x * RECIP / 2^(POS_W+AW)) is exact for any 32-bit x; rem = x - q * DIVISOR
    localparam logic [63:0] NUMER    = 64'd1 << (POS_W + AW);
    localparam logic [63:0] RECIP    = (NUMER + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];

    logic              r_done;
    logic [2:0]        r_pipe;
    logic [POS_W-1:0]  r_x;
    logic [POS_W+15:0] r_plo;
    logic [POS_W+16:0] r_phi;
    logic [AW-1:0]     r_qlo;
    logic [AW-1:0]     r_rem;
    logic [PW-1:0]     w_prod;
    logic [AW-1:0]     w_qs;

    // only the low AW bits of the quotient matter for the remainder
    assign w_prod = {r_phi, 16'b0} + PW'(r_plo);
    assign w_qs   = r_qlo * AW'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_pipe <= '0;
            r_x    <= '0;
            r_plo  <= '0;
            r_phi  <= '0;
            r_qlo  <= '0;
            r_rem  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !POW2) begin
                r_pipe <= 3'b001;
            end else begin
                r_pipe <= {r_pipe[1:0], 1'b0};
            end
            if (i_start) begin
                if (POW2) begin
                    r_rem  <= i_value[AW-1:0];
                    r_done <= 1'b1;
                end else begin
                    r_x <= i_value;
                end
            end
            if (r_pipe[0]) begin
                r_plo <= (POS_W+16)'(r_x) * (POS_W+16)'(RECIP_LO);
                r_phi <= (POS_W+17)'(r_x) * (POS_W+17)'(RECIP_HI);
            end
            if (r_pipe[1]) begin
                r_qlo <= w_prod[POS_W+AW +: AW];
            end
            if (r_pipe[2]) begin
                r_rem  <= r_x[AW-1:0] - w_qs;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/prbb_dp.sv
`timescale 1ns / 1ps

module prbb_dp #(
    parameter int SLOTS        = 256,
    parameter int PAYLOAD_BITS = 64,
    parameter int MAX_BATCH    = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prbb_pkg::t_cmd               i_cmd,
    output prbb_pkg::t_stat              o_stat,
    input  logic                         i_cfg_we,
    input  logic [prbb_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic [prbb_pkg::MODE_W-1:0]  i_mode,
    input  logic [prbb_pkg::FIELD_W-1:0] i_payload_in,
    input  logic [prbb_pkg::POS_W-1:0]   i_position,
    output logic                         o_strobe,
    output logic [prbb_pkg::FIELD_W-1:0] o_payload_out,
    output logic [prbb_pkg::STAT_W-1:0]  o_status,
    output logic                         o_last,
    output logic [prbb_pkg::POS_W-1:0]   o_item_position
);

    import prbb_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);

    // captured command word
    logic [MODE_W-1:0]       r_mode;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [POS_W-1:0]        r_position;

    logic [POS_W-1:0]   r_wc;
    logic [POS_W-1:0]   r_rc;
    logic [SLOT_W-1:0]  r_wslot;
    logic [SLOT_W-1:0]  r_rslot;
    logic [CNT_W-1:0]   r_remain;
    logic [LIMIT_W-1:0] r_limit;

    logic               r_out_vld;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_last;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_ram;

    logic [POS_W-1:0]        w_used;
    logic                    w_full;
    logic                    w_empty;
    logic [LIMIT_W-1:0]      w_lim;
    logic [CNT_W-1:0]        w_count;
    logic [SLOT_W-1:0]       w_wslot_nx;
    logic [SLOT_W-1:0]       w_rslot_nx;
    logic                    w_is_push;
    logic                    w_is_pop;
    logic                    w_is_peek;
    logic                    w_is_setr;
    logic                    w_is_setw;
    logic                    w_mod_done;
    logic [SLOT_W-1:0]       w_mod_rem;
    logic                    w_ram_we;
    logic                    w_ram_re;
    logic [SLOT_W-1:0]       w_ram_raddr;
    logic [PAYLOAD_BITS-1:0] w_ram_q;

    assign w_is_push = (r_mode == MODE_PUSH);
    assign w_is_pop  = (r_mode == MODE_POP);
    assign w_is_peek = (r_mode == MODE_PEEK);
    assign w_is_setr = (r_mode == MODE_SETR);
    assign w_is_setw = (r_mode == MODE_SETW);

    assign w_used  = r_wc - r_rc;
    assign w_full  = (w_used >= POS_W'(SLOTS));
    assign w_empty = (w_used == '0);

    always_comb begin
        if (r_limit == '0) begin
            w_lim = LIMIT_W'(1);
        end else if (r_limit > LIMIT_W'(MAX_BATCH)) begin
            w_lim = LIMIT_W'(MAX_BATCH);
        end else begin
            w_lim = r_limit;
        end
    end

    assign w_count = (w_used < POS_W'(w_lim)) ? CNT_W'(w_used) : CNT_W'(w_lim);

    // counter wrap restarts the slot at 0
    assign w_wslot_nx = (r_wslot == SLOT_W'(SLOTS - 1) || r_wc == '1) ? '0 : r_wslot + 1'b1;
    assign w_rslot_nx = (r_rslot == SLOT_W'(SLOTS - 1) || r_rc == '1) ? '0 : r_rslot + 1'b1;

    assign o_stat.pop_go   = w_is_pop && !w_empty;
    assign o_stat.need_mod = w_is_peek || w_is_setr || w_is_setw;
    assign o_stat.mod_done = w_mod_done;
    assign o_stat.pop_last = (r_remain == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_payload  <= i_payload_in[PAYLOAD_BITS-1:0];
            r_position <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc         <= '0;
            r_rc         <= '0;
            r_wslot      <= '0;
            r_rslot      <= '0;
            r_remain     <= '0;
            r_limit      <= LIMIT_RESET;
            r_out_vld    <= 1'b0;
            r_out_status <= STAT_OK;
            r_out_last   <= 1'b0;
            r_out_pos    <= '0;
            r_out_ram    <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                if (w_is_push) begin
                    r_out_vld    <= 1'b1;
                    r_out_last   <= 1'b1;
                    r_out_pos    <= r_wc;
                    r_out_ram    <= 1'b0;
                    r_out_status <= w_full ? STAT_FULL : STAT_OK;
                    if (!w_full) begin
                        r_wc    <= r_wc + 1'b1;
                        r_wslot <= w_wslot_nx;
                    end
                end else if (w_is_pop) begin
                    if (w_empty) begin
                        r_out_vld    <= 1'b1;
                        r_out_last   <= 1'b1;
                        r_out_pos    <= r_rc;
                        r_out_ram    <= 1'b0;
                        r_out_status <= STAT_EMPTY;
                    end else begin
                        r_remain <= w_count;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_out_vld    <= 1'b1;
                r_out_last   <= 1'b1;
                r_out_pos    <= r_position;
                r_out_ram    <= w_is_peek;
                r_out_status <= STAT_OK;
                if (w_is_setr) begin
                    r_rc    <= r_position;
                    r_rslot <= w_mod_rem;
                end
                if (w_is_setw) begin
                    r_wc    <= r_position;
                    r_wslot <= w_mod_rem;
                end
            end
            if (i_cmd.pop_step) begin
                r_out_vld    <= 1'b1;
                r_out_last   <= o_stat.pop_last;
                r_out_pos    <= r_rc;
                r_out_ram    <= 1'b1;
                r_out_status <= STAT_OK;
                r_rc         <= r_rc + 1'b1;
                r_rslot      <= w_rslot_nx;
                r_remain     <= r_remain - 1'b1;
            end
        end
    end

    prbb_mod #(
        .DIVISOR (SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exec && o_stat.need_mod),
        .i_value (r_position),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    assign w_ram_we    = i_cmd.exec && w_is_push && !w_full;
    assign w_ram_re    = i_cmd.pop_step || (i_cmd.finish && w_is_peek);
    assign w_ram_raddr = i_cmd.pop_step ? r_rslot : w_mod_rem;

    prbb_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_payload),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    assign o_strobe        = r_out_vld;
    assign o_payload_out   = r_out_ram ? FIELD_W'(w_ram_q) : '0;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;
    assign o_item_position = r_out_pos;

`ifndef SYNTHESIS
    a_pop_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_step |-> (r_remain != '0))
        else $error("pop step with no entries left");

    a_push_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_is_push && !w_full) |=> (r_wc == $past(r_wc) + 1'b1))
        else $error("accepted push did not advance write counter");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (POS_W'(r_wslot) < POS_W'(SLOTS)) && (POS_W'(r_rslot) < POS_W'(SLOTS)))
        else $error("slot index out of range");

    a_ram_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ram) |-> (r_out_status == STAT_OK))
        else $error("read word with non-ok status");
`endif

endmodule

FILE: hdl/prbb_ctrl.sv
`timescale 1ns / 1ps

module prbb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  prbb_pkg::t_stat i_stat,
    output prbb_pkg::t_cmd  o_cmd
);

    import prbb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_MODW = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.pop_go) begin
                    n_state = ST_POP;
                end else if (i_stat.need_mod) begin
                    n_state = ST_MODW;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MODW: begin
                if (i_stat.mod_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                if (i_stat.pop_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cmd.load     = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec     = (r_state == ST_EXEC);
    assign o_cmd.finish   = (r_state == ST_MODW) && i_stat.mod_done;
    assign o_cmd.pop_step = (r_state == ST_POP);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_pop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP && i_stat.pop_last) |=> (r_state == ST_IDLE))
        else $error("batch pop ran past its last entry");
`endif

endmodule

FILE: hdl/packet_ring_buffer_batch_unit.sv
`timescale 1ns / 1ps
// Sequence: an accepted word is captured, then executed; a push or empty-pop result is registered
//   from the execute state. Peek and set wait for the slot remainder (a multiply pipeline when SLOTS
//   is not a power of two) and then finish; a pop of n entries steps through them in turn, its
//   results on consecutive cycles, one RAM read each. A new word is taken only once busy drops.
// The receiver cannot stall.
// Reset (synchronous, active low): counters 0, batch limit 16; slot RAM not cleared.
module packet_ring_buffer_batch_unit #(
    parameter int SLOTS        = 256,
    parameter int PAYLOAD_BITS = 64,
    parameter int MAX_BATCH    = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [prbb_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic [prbb_pkg::MODE_W-1:0]  i_mode,
    input  logic [prbb_pkg::FIELD_W-1:0] i_payload_in,
    input  logic [prbb_pkg::POS_W-1:0]   i_position,
    output logic                         o_strobe,
    output logic [prbb_pkg::FIELD_W-1:0] o_payload_out,
    output logic [prbb_pkg::STAT_W-1:0]  o_status,
    output logic                         o_last,
    output logic [prbb_pkg::POS_W-1:0]   o_item_position
);

    import prbb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    prbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    prbb_dp #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .MAX_BATCH    (MAX_BATCH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_payload_in    (i_payload_in),
        .i_position      (i_position),
        .o_strobe        (o_strobe),
        .o_payload_out   (o_payload_out),
        .o_status        (o_status),
        .o_last          (o_last),
        .o_item_position (o_item_position)
    );

endmodule
